// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros included by the escape counter top file.
// Each macro places one labeled concurrent assertion on the rising clock edge,
// disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Assert that a condition is followed in the next cycle by a consequence.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mec_pkg.sv =====
// ---------------------------------------------------------------------------
// Mandelbrot escape counter package
// Fixed-point formats, datapath widths and shared types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mec_pkg;

    // Fraction bits of the Q4.28 point format.
    localparam int FRAC_BITS = 28;

    // Width of one point component and of the iteration counter.
    localparam int Z_W    = 32;
    localparam int ITER_W = 16;

    // Full product, floored square, cross term and new-component widths.
    localparam int P_W  = 2 * Z_W;
    localparam int SQ_W = P_W - FRAC_BITS;
    localparam int CR_W = P_W - FRAC_BITS + 1;
    localparam int N_W  = P_W - FRAC_BITS + 2;

    // Width of the count field in a result.
    localparam int OUT_CNT_W = 24;

    typedef logic signed [Z_W-1:0]  t_z;
    typedef logic signed [P_W-1:0]  t_prod;
    typedef logic signed [SQ_W-1:0] t_sq;
    typedef logic signed [N_W-1:0]  t_next;
    typedef logic [ITER_W-1:0]      t_iter;

    // Escape bounds: 2.0 for one component and 4.0 for the magnitude squared.
    localparam t_next TWO_FX  = t_next'(2) <<< FRAC_BITS;
    localparam t_next FOUR_FX = t_next'(4) <<< FRAC_BITS;

endpackage

`default_nettype wire

// ===== hw/rtl/mandelbrot_escape_counter_top.sv =====
// ---------------------------------------------------------------------------
// Mandelbrot escape counter
// Escape-time iteration of one Q4.28 point per transfer with a running,
// saturating count of escaped points.
// ---------------------------------------------------------------------------
// Each input transfer carries one point c. The block starts from z = c and
// repeats z = z*z + c until |z|^2 exceeds 4.0, a component of the new z
// exceeds 2.0 or the configured iteration limit is reached, then emits one
// result with the escape flag, the step number and the escaped-point count.
// All products go through one shared 32x32 signed multiplier, so each step
// runs through the states SQR, SQI, CRS and UPD (three products and one
// update). The input side is ready only while no point is in work; a
// finished result sits in the output register, so the next point may be
// accepted while it waits. A limit of zero returns a non-escaped result with
// zero steps.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mandelbrot_escape_counter_top #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Configuration write channel: iteration limit.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,

    // Input points.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,  // [31:0] c_real, [63:32] c_imag
    input  wire logic        i_s_axis_tuser,  // [0] clear_count

    // Results.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,  // [15:0] iterations_used,
                                              // [39:16] outside_count
    output logic             o_m_axis_tuser   // [0] escaped
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQR  = 3'd1;
    localparam logic [2:0] ST_SQI  = 3'd2;
    localparam logic [2:0] ST_CRS  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    // The count field shows the low bits of a count of any width.
    localparam int CNT_EXT_W = (COUNT_BITS > mec_pkg::OUT_CNT_W) ?
                               COUNT_BITS : mec_pkg::OUT_CNT_W;

    logic [2:0]              r_state, n_state;
    mec_pkg::t_z             r_zr, n_zr, r_zi, n_zi;
    mec_pkg::t_z             r_cr, n_cr, r_ci, n_ci;
    mec_pkg::t_iter          r_it, n_it;
    mec_pkg::t_iter          r_max_iter, n_max_iter;
    mec_pkg::t_iter          r_used, n_used;
    logic                    r_esc, n_esc;
    logic                    r_clear, n_clear;
    mec_pkg::t_prod          r_prod, n_prod;
    mec_pkg::t_sq            r_sq_r, n_sq_r, r_sq_i, n_sq_i;
    logic [COUNT_BITS-1:0]   r_total, n_total;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_esc, n_out_esc;
    mec_pkg::t_iter          r_out_used, n_out_used;
    logic [mec_pkg::OUT_CNT_W-1:0] r_out_cnt, n_out_cnt;

    mec_pkg::t_z             w_mul_a, w_mul_b;
    logic signed [mec_pkg::CR_W-1:0] w_cross;
    mec_pkg::t_next          w_nr, w_ni;
    logic signed [mec_pkg::SQ_W:0]   w_mag;
    logic                    w_mag_esc, w_out_bound;
    logic [COUNT_BITS-1:0]   w_base, w_total;
    logic [CNT_EXT_W-1:0]    w_total_ext;
    logic                    w_in_xfer, w_out_free;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_esc;
    assign o_m_axis_tdata  = {r_out_cnt, r_out_used};

    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_state)
            ST_SQI: begin
                w_mul_a = r_zi;
                w_mul_b = r_zi;
            end
            ST_CRS: begin
                w_mul_a = r_zr;
                w_mul_b = r_zi;
            end
            default: begin
                w_mul_a = r_zr;
                w_mul_b = r_zr;
            end
        endcase
    end

    // Step update: floored products combine into the next z, and the squares
    // of the current z give its magnitude test.
    assign w_cross = $signed(r_prod[mec_pkg::P_W-1:mec_pkg::FRAC_BITS-1]);
    assign w_nr    = mec_pkg::N_W'(r_sq_r) - mec_pkg::N_W'(r_sq_i) + mec_pkg::N_W'(r_cr);
    assign w_ni    = mec_pkg::N_W'(w_cross) + mec_pkg::N_W'(r_ci);
    assign w_mag   = (mec_pkg::SQ_W + 1)'(r_sq_r) + (mec_pkg::SQ_W + 1)'(r_sq_i);
    assign w_mag_esc   = (mec_pkg::N_W'(w_mag) > mec_pkg::FOUR_FX);
    assign w_out_bound = (w_nr > mec_pkg::TWO_FX) || (w_nr < -mec_pkg::TWO_FX) ||
                         (w_ni > mec_pkg::TWO_FX) || (w_ni < -mec_pkg::TWO_FX);

    // Saturating escaped-point count after the finished point.
    assign w_base      = r_clear ? '0 : r_total;
    assign w_total     = (r_esc && (w_base != '1)) ? w_base + COUNT_BITS'(1) : w_base;
    assign w_total_ext = CNT_EXT_W'(w_total);

    // Sequencer and datapath next values.
    always_comb begin
        n_state     = r_state;
        n_zr        = r_zr;
        n_zi        = r_zi;
        n_cr        = r_cr;
        n_ci        = r_ci;
        n_it        = r_it;
        n_used      = r_used;
        n_esc       = r_esc;
        n_clear     = r_clear;
        n_prod      = w_mul_a * w_mul_b;
        n_sq_r      = r_sq_r;
        n_sq_i      = r_sq_i;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        n_out_esc   = r_out_esc;
        n_out_used  = r_out_used;
        n_out_cnt   = r_out_cnt;
        n_max_iter  = r_max_iter;

        if (i_cfg_valid) begin
            n_max_iter = i_cfg_data;
        end
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_cr    = $signed(i_s_axis_tdata[31:0]);
                    n_ci    = $signed(i_s_axis_tdata[63:32]);
                    n_zr    = $signed(i_s_axis_tdata[31:0]);
                    n_zi    = $signed(i_s_axis_tdata[63:32]);
                    n_clear = i_s_axis_tuser;
                    n_it    = '0;
                    n_esc   = 1'b0;
                    n_used  = '0;
                    n_state = (r_max_iter == '0) ? ST_FIN : ST_SQR;
                end
            end
            ST_SQR: begin
                n_state = ST_SQI;
            end
            ST_SQI: begin
                n_sq_r  = $signed(r_prod[mec_pkg::P_W-1:mec_pkg::FRAC_BITS]);
                n_state = ST_CRS;
            end
            ST_CRS: begin
                n_sq_i  = $signed(r_prod[mec_pkg::P_W-1:mec_pkg::FRAC_BITS]);
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if ((r_it != '0) && w_mag_esc) begin
                    // The current z fails the magnitude test.
                    n_esc   = 1'b1;
                    n_used  = r_it;
                    n_state = ST_FIN;
                end else if (r_it == r_max_iter) begin
                    n_used  = r_max_iter;
                    n_state = ST_FIN;
                end else if (w_out_bound) begin
                    // One component of the new z is already beyond 2.0.
                    n_esc   = 1'b1;
                    n_used  = r_it + mec_pkg::ITER_W'(1);
                    n_state = ST_FIN;
                end else begin
                    n_zr    = mec_pkg::Z_W'(w_nr);
                    n_zi    = mec_pkg::Z_W'(w_ni);
                    n_it    = r_it + mec_pkg::ITER_W'(1);
                    n_state = ST_SQR;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_total     = w_total;
                    n_out_valid = 1'b1;
                    n_out_esc   = r_esc;
                    n_out_used  = r_used;
                    n_out_cnt   = w_total_ext[mec_pkg::OUT_CNT_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_max_iter  <= mec_pkg::ITER_W'(2000);
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            r_max_iter  <= n_max_iter;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_zr       <= n_zr;
        r_zi       <= n_zi;
        r_cr       <= n_cr;
        r_ci       <= n_ci;
        r_it       <= n_it;
        r_used     <= n_used;
        r_esc      <= n_esc;
        r_clear    <= n_clear;
        r_prod     <= n_prod;
        r_sq_r     <= n_sq_r;
        r_sq_i     <= n_sq_i;
        r_out_esc  <= n_out_esc;
        r_out_used <= n_out_used;
        r_out_cnt  <= n_out_cnt;
    end

    // An escaped point always reports a step number of one or more.
    `ASSERT_CLK(a_esc_step, i_clk, i_rst_n, (r_out_valid && r_out_esc) |-> (r_out_used != '0), "escaped result with zero steps")
    // A stored z after the first step lies within the component bound.
    `ASSERT_CLK(a_z_bound, i_clk, i_rst_n, ((r_state == ST_SQR) && (r_it != '0)) |-> ((mec_pkg::N_W'(r_zr) <= mec_pkg::TWO_FX) && (mec_pkg::N_W'(r_zr) >= -mec_pkg::TWO_FX) && (mec_pkg::N_W'(r_zi) <= mec_pkg::TWO_FX) && (mec_pkg::N_W'(r_zi) >= -mec_pkg::TWO_FX)), "stored z beyond bound")
    // The count moves only when a finished point is handed to the output.
    `ASSERT_NEXT(a_total_hold, i_clk, i_rst_n, (r_state != ST_FIN), $stable(r_total), "count changed outside finish")
    // An accepted point always starts work.
    `ASSERT_NEXT(a_start, i_clk, i_rst_n, w_in_xfer, (r_state == ST_SQR) || (r_state == ST_FIN), "accepted point did not start")

endmodule

`default_nettype wire
